FILE: rtl/ces_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ces_pkg
// Shared constants, types and helpers of the encoder speed estimator.
// ---------------------------------------------------------------------------
package ces_pkg;

    // event ring
    localparam int HIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(HIST_DEPTH);

    // operation codes
    localparam logic [1:0] OP_EDGE    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // direction codes stored with each event
    localparam logic [1:0] DIR_STALL = 2'd0;
    localparam logic [1:0] DIR_FWD   = 2'd1;
    localparam logic [1:0] DIR_REV   = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TPR     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 8'd3;

    // configuration reset values
    localparam logic [12:0] TPR_RST     = 13'd12;
    localparam logic [10:0] GEAR_RST    = 11'd1;
    localparam logic [31:0] TIMEOUT_RST = 32'd100000;
    localparam logic [31:0] WINDOW_RST  = 32'd200000;

    // arithmetic constants (rpm in Q24.7: 60 * 1e6 * 128)
    localparam logic [32:0] RPM_NUM     = 33'd7680000000;
    localparam logic [31:0] MIN_DT_US   = 32'd10;
    localparam logic [7:0]  HIGH_DUTY   = 8'd230;
    localparam logic [7:0]  DUTY_STEP   = 8'd5;
    localparam logic [8:0]  WEAK_MARGIN = 9'd50;
    localparam logic [7:0]  NTD_RST     = 8'd50;
    localparam logic [4:0]  PEAK_KEEP   = 5'd19;
    localparam logic [4:0]  PEAK_DIV    = 5'd20;

    // divider widths
    localparam int DIV_W = 38;
    localparam int DEN_W = 56;

    // payload widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 120;

    typedef enum logic [1:0] {
        DSEL_RPM,
        DSEL_AVG,
        DSEL_PEAK
    } div_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load_item;
        logic     exec;
        logic     q_init;
        logic     q_check;
        logic     q_skip;
        logic     q_mul;
        logic     div_start;
        div_sel_t div_sel;
        logic     q_acc;
        logic     avg_take;
        logic     peak_take;
        logic     peak_avg;
        logic     out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       win_break;
        logic       dt_ok;
        logic       last_step;
        logic       div_done;
        logic       count_zero;
        logic       high_duty;
        logic       res_gt_peak;
        logic       out_full;
    } sts_t;

    function automatic logic [7:0] weak_of(input logic [7:0] d);
        logic [8:0] w;
        w = {1'b0, d} + WEAK_MARGIN;
        return w[8] ? 8'hFF : w[7:0];
    endfunction

endpackage

FILE: rtl/ces_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ces_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ces_div
    import ces_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;

    // one restoring step
    always_comb begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        if (shifted >= {1'b0, den_reg}) begin
            rem_next = DEN_W'(shifted - {1'b0, den_reg});
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end else begin
            rem_next = shifted[DEN_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/ces_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ces_datapath
// Event ring, position and duty state, query accumulators and result register.
// ---------------------------------------------------------------------------
module ces_datapath
    import ces_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [1:0]           s_op,
    input  logic [S_DATA_W-1:0]  s_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_wdata,
    output logic [M_DATA_W-1:0]  m_data,
    output logic                 m_valid,
    input  logic                 m_ready
);

    // configuration
    logic [12:0] tpr_reg;
    logic [10:0] gear_reg;
    logic [31:0] timeout_reg;
    logic [31:0] window_reg;

    // captured item
    logic [1:0]  op_reg;
    logic        enc_a_reg, enc_b_reg;
    logic [31:0] now_reg;
    logic [7:0]  duty_reg;

    // event ring; time and direction read as zero until valid
    logic [31:0]           ev_time [HIST_DEPTH];
    logic [1:0]            ev_dir  [HIST_DEPTH];
    logic [7:0]            ev_duty [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] tval_reg;
    logic [HIST_DEPTH-1:0] dval_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [IDX_W-1:0]      walk_reg;
    logic [IDX_W-1:0]      step_reg;

    // block state
    logic [31:0]        tick_reg;
    logic signed [31:0] peak_reg;
    logic [7:0]         ntd_reg;
    logic               kick_reg;

    // query registers
    logic [31:0]        new_time_reg;
    logic [1:0]         new_dir_reg;
    logic [7:0]         new_duty_reg;
    logic [23:0]        k_reg;
    logic [31:0]        dt_reg;
    logic [DEN_W-1:0]   den_reg;
    logic signed [37:0] sum_reg;
    logic [11:0]        dsum_reg;
    logic [3:0]         count_reg;
    logic signed [31:0] res_reg;

    // output register
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_valid_reg;

    // ring read at the walk index
    logic [31:0] rd_time;
    logic [1:0]  rd_dir;
    logic [7:0]  rd_duty;
    assign rd_time = tval_reg[walk_reg] ? ev_time[walk_reg] : 32'd0;
    assign rd_dir  = tval_reg[walk_reg] ? ev_dir[walk_reg]  : DIR_STALL;
    assign rd_duty = dval_reg[walk_reg] ? ev_duty[walk_reg] : 8'd0;

    // divider operand selection
    logic [DIV_W-1:0]   div_a;
    logic [DEN_W-1:0]   div_b;
    logic [DIV_W-1:0]   div_q;
    logic               div_done;
    logic [DIV_W-1:0]   sum_abs;
    logic signed [37:0] pk_val;
    logic [DIV_W-1:0]   pk_abs;

    assign sum_abs = sum_reg[37] ? DIV_W'(-sum_reg) : DIV_W'(sum_reg);
    assign pk_val  = $signed({{6{peak_reg[31]}}, peak_reg}) * $signed({33'd0, PEAK_KEEP})
                   + $signed({{6{res_reg[31]}}, res_reg});
    assign pk_abs  = pk_val[37] ? DIV_W'(-pk_val) : DIV_W'(pk_val);

    always_comb begin
        case (cmd.div_sel)
            DSEL_RPM: begin
                div_a = DIV_W'(RPM_NUM);
                div_b = den_reg;
            end
            DSEL_AVG: begin
                div_a = sum_abs;
                div_b = DEN_W'(count_reg);
            end
            DSEL_PEAK: begin
                div_a = pk_abs;
                div_b = DEN_W'(PEAK_DIV);
            end
            default: begin
                div_a = '0;
                div_b = '1;
            end
        endcase
    end

    ces_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // derived values
    logic [31:0]        delta_to;
    logic [31:0]        dt_now;
    logic [31:0]        age;
    logic [12:0]        tpr_eff;
    logic [10:0]        gear_eff;
    logic [38:0]        avg_s;
    logic signed [31:0] avg_sat;
    logic [37:0]        pk_q_s;
    logic [11:0]        dlimit;
    logic [37:0]        mag;

    assign delta_to = now_reg - rd_time;
    assign dt_now   = new_time_reg - rd_time;
    assign age      = now_reg - new_time_reg;
    assign tpr_eff  = (tpr_reg == '0) ? 13'd1 : tpr_reg;
    assign gear_eff = (gear_reg == '0) ? 11'd1 : gear_reg;
    assign avg_s    = sum_reg[37] ? 39'(-{1'b0, div_q}) : {1'b0, div_q};
    assign pk_q_s   = pk_val[37] ? 38'(-div_q) : div_q;
    assign dlimit   = 12'(count_reg * 8'(HIGH_DUTY + 8'd1));
    assign mag      = {1'b0, div_q[36:0]};

    // saturate averaged rpm to 32 bits
    always_comb begin
        if ($signed(avg_s) > 39'sd2147483647) begin
            avg_sat = 32'sh7FFFFFFF;
        end else if ($signed(avg_s) < -39'sd2147483648) begin
            avg_sat = 32'sh80000000;
        end else begin
            avg_sat = avg_s[31:0];
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpr_reg     <= TPR_RST;
            gear_reg    <= GEAR_RST;
            timeout_reg <= TIMEOUT_RST;
            window_reg  <= WINDOW_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_TPR:     tpr_reg     <= cfg_wdata[12:0];
                CFG_GEAR:    gear_reg    <= cfg_wdata[10:0];
                CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                CFG_WINDOW:  window_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // item capture and query payload
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= s_op;
            enc_a_reg <= s_data[0];
            enc_b_reg <= s_data[1];
            now_reg   <= s_data[33:2];
            duty_reg  <= s_data[41:34];
            res_reg   <= '0;
        end
        if (cmd.q_init) begin
            new_time_reg <= rd_time;
            new_dir_reg  <= rd_dir;
            new_duty_reg <= rd_duty;
            k_reg        <= 24'(tpr_eff * gear_eff);
            sum_reg      <= '0;
            dsum_reg     <= '0;
            count_reg    <= '0;
            step_reg     <= IDX_W'(1);
        end
        if (cmd.q_check) begin
            dt_reg <= dt_now;
        end
        if (cmd.q_mul) begin
            den_reg <= DEN_W'(k_reg * dt_reg);
        end
        if (cmd.q_skip) begin
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.q_acc) begin
            if (new_dir_reg == DIR_FWD) begin
                sum_reg <= sum_reg + $signed(mag);
            end else if (new_dir_reg == DIR_REV) begin
                sum_reg <= sum_reg - $signed(mag);
            end
            dsum_reg     <= dsum_reg + 12'(new_duty_reg);
            count_reg    <= count_reg + 1'b1;
            new_time_reg <= rd_time;
            new_dir_reg  <= rd_dir;
            new_duty_reg <= rd_duty;
            step_reg     <= step_reg + 1'b1;
        end
        if (cmd.avg_take) begin
            res_reg <= avg_sat;
        end
    end

    // event ring payload
    always_ff @(posedge aclk) begin
        if (cmd.exec && (op_reg == OP_EDGE)) begin
            ev_time[slot_reg] <= now_reg;
            ev_dir[slot_reg]  <= (enc_a_reg ^ enc_b_reg) ? DIR_REV : DIR_FWD;
            ev_duty[slot_reg] <= duty_reg;
        end else if (cmd.exec && (op_reg == OP_TIMEOUT) && (delta_to >= timeout_reg)) begin
            ev_time[slot_reg] <= now_reg;
            ev_dir[slot_reg]  <= DIR_STALL;
            ev_duty[slot_reg] <= duty_reg;
        end
    end

    // ring control, position, stall state and peak
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tval_reg <= '0;
            dval_reg <= '0;
            slot_reg <= '0;
            walk_reg <= '0;
            tick_reg <= '0;
            peak_reg <= '0;
            ntd_reg  <= NTD_RST;
            kick_reg <= 1'b1;
        end else begin
            if (cmd.load_item) begin
                walk_reg <= slot_reg - 1'b1;
            end
            if (cmd.q_init || cmd.q_skip || cmd.q_acc) begin
                walk_reg <= walk_reg - 1'b1;
            end
            if (cmd.exec) begin
                unique case (op_reg)
                    OP_EDGE: begin
                        tval_reg[slot_reg] <= 1'b1;
                        dval_reg[slot_reg] <= 1'b1;
                        slot_reg           <= slot_reg + 1'b1;
                        tick_reg <= (enc_a_reg ^ enc_b_reg) ? tick_reg - 1'b1
                                                            : tick_reg + 1'b1;
                    end
                    OP_TIMEOUT: begin
                        if (delta_to >= timeout_reg) begin
                            tval_reg[slot_reg] <= 1'b1;
                            dval_reg[slot_reg] <= 1'b1;
                            slot_reg           <= slot_reg + 1'b1;
                            kick_reg           <= 1'b1;
                            if (duty_reg > ntd_reg) begin
                                ntd_reg <= duty_reg;
                            end
                        end else if (duty_reg < weak_of(ntd_reg)) begin
                            ntd_reg <= (ntd_reg > DUTY_STEP) ? ntd_reg - DUTY_STEP : 8'd0;
                        end
                    end
                    OP_CLEAR: begin
                        tick_reg <= '0;
                        tval_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.peak_take) begin
                peak_reg <= res_reg;
            end
            if (cmd.peak_avg) begin
                peak_reg <= pk_q_s[31:0];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {7'd0, kick_reg, weak_of(ntd_reg), ntd_reg, tick_reg,
                           peak_reg, res_reg};
        end
    end

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

    // status
    assign sts.op          = op_reg;
    assign sts.win_break   = age > window_reg;
    assign sts.dt_ok       = dt_reg > MIN_DT_US;
    assign sts.last_step   = step_reg == IDX_W'(HIST_DEPTH - 1);
    assign sts.div_done    = div_done;
    assign sts.count_zero  = count_reg == '0;
    assign sts.high_duty   = dsum_reg >= dlimit;
    assign sts.res_gt_peak = res_reg > peak_reg;
    assign sts.out_full    = m_valid_reg && !m_ready;

endmodule

FILE: rtl/ces_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ces_ctrl
// Sequencer for item execution and the rpm query walk.
// ---------------------------------------------------------------------------
module ces_ctrl
    import ces_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_QINIT,
        S_QCHECK,
        S_QMUL,
        S_QDIV,
        S_QWAIT,
        S_AVG,
        S_AVGW,
        S_PEAK,
        S_PKW,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DSEL_RPM;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.op == OP_QUERY) begin
                    state_next = S_QINIT;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_QINIT: begin
                cmd.q_init = 1'b1;
                state_next = S_QCHECK;
            end
            S_QCHECK: begin
                cmd.q_check = 1'b1;
                if (sts.win_break) begin
                    state_next = S_AVG;
                end else begin
                    state_next = S_QMUL;
                end
            end
            S_QMUL: begin
                if (sts.dt_ok) begin
                    cmd.q_mul  = 1'b1;
                    state_next = S_QDIV;
                end else begin
                    cmd.q_skip = 1'b1;
                    state_next = sts.last_step ? S_AVG : S_QCHECK;
                end
            end
            S_QDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_RPM;
                state_next    = S_QWAIT;
            end
            S_QWAIT: begin
                if (sts.div_done) begin
                    cmd.q_acc  = 1'b1;
                    state_next = sts.last_step ? S_AVG : S_QCHECK;
                end
            end
            S_AVG: begin
                if (sts.count_zero) begin
                    state_next = S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_AVG;
                    state_next    = S_AVGW;
                end
            end
            S_AVGW: begin
                cmd.div_sel = DSEL_AVG;
                if (sts.div_done) begin
                    cmd.avg_take = 1'b1;
                    state_next   = S_PEAK;
                end
            end
            S_PEAK: begin
                if (!sts.high_duty) begin
                    state_next = S_FIN;
                end else if (sts.res_gt_peak) begin
                    cmd.peak_take = 1'b1;
                    state_next    = S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_PEAK;
                    state_next    = S_PKW;
                end
            end
            S_PKW: begin
                cmd.div_sel = DSEL_PEAK;
                if (sts.div_done) begin
                    cmd.peak_avg = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN: begin
                if (!sts.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

FILE: rtl/encoder_speed_estimator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// encoder_speed_estimator
// Quadrature encoder event ring with windowed rpm estimate and stall tracking.
// ---------------------------------------------------------------------------
// Edge, timeout and clear items pass from accept through the execute state to
// the result register. An rpm query walks the ring: each valid interval of the
// walk runs the restoring divider, as do the average and the peak update.
// One item is in work at a time.
// Synchronous active-low reset restores the register defaults and empties the
// event ring at once through per-entry valid bits.
module encoder_speed_estimator
    import ces_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // enc_a, enc_b, now_us[31:0], duty[7:0]
    input  logic [1:0]           s_tuser,   // operation[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // rpm[31:0], max_rpm[31:0], position_ticks[31:0], stall_duty[7:0],
    // weak_duty[7:0], kick_needed
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    ces_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ces_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_op      (s_tuser),
        .s_data    (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .m_data    (m_tdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready)
    );

endmodule

FILE: tb/speed_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// speed_checker
// Watches the item, result and register channels of the encoder speed
// estimator, keeps its own copy of the event ring and registers, predicts
// every result and compares it with what the block returns.
// ---------------------------------------------------------------------------
module speed_checker
    import ces_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic [31:0] rpm;
        logic [31:0] max_rpm;
        logic [31:0] pos;
        logic [7:0]  stall;
        logic [7:0]  weak_duty;
        logic        kick;
    } speed_out_t;

    // register copies
    logic [12:0] tpr;
    logic [10:0] gear;
    logic [31:0] stall_to;
    logic [31:0] win;

    // event ring and tracking state
    logic [31:0]          ev_time [HIST_DEPTH];
    logic [1:0]           ev_dir  [HIST_DEPTH];
    logic [7:0]           ev_duty [HIST_DEPTH];
    logic [IDX_W-1:0]     slot;
    logic [31:0]          ticks;
    logic signed [31:0]   peak;
    logic [7:0]           ntd;
    logic                 kick;

    speed_out_t expected_outputs[$];

    function automatic logic [7:0] weak_level(input logic [7:0] d);
        logic [8:0] w;
        w = {1'b0, d} + 9'd50;
        return (w > 9'd255) ? 8'd255 : w[7:0];
    endfunction

    task automatic push_event(input logic [31:0] t, input logic [1:0] dir,
                              input logic [7:0] d);
        ev_time[slot] = t;
        ev_dir[slot]  = dir;
        ev_duty[slot] = d;
        slot = slot + 1'b1;
    endtask

    // windowed rpm average, updates the peak at high duty
    task automatic average_rpm(input logic [31:0] now, output logic [31:0] rpm);
        logic [31:0]       tim [HIST_DEPTH];
        logic [1:0]        dr  [HIST_DEPTH];
        logic [7:0]        du  [HIST_DEPTH];
        logic [IDX_W-1:0]  i;
        logic [IDX_W-1:0]  j;
        logic [31:0]       dt;
        logic [31:0]       age;
        longint unsigned   den;
        longint unsigned   mag;
        longint            sum;
        longint            res;
        int unsigned       dsum;
        int unsigned       cnt;
        tim = ev_time;
        dr  = ev_dir;
        du  = ev_duty;
        den = longint'(tpr == 0 ? 13'd1 : tpr) * longint'(gear == 0 ? 11'd1 : gear);
        sum = 0;
        dsum = 0;
        cnt = 0;
        rpm = 0;
        for (int s = 1; s < HIST_DEPTH; s++) begin
            i   = slot - IDX_W'(s);
            j   = slot - IDX_W'(s) - 1'b1;
            dt  = tim[i] - tim[j];
            age = now - tim[i];
            if (age > win) break;
            if (dt > MIN_DT_US) begin
                mag = 64'(RPM_NUM) / (den * 64'(dt));
                if (dr[i] == DIR_FWD) sum = sum + longint'(mag);
                else if (dr[i] == DIR_REV) sum = sum - longint'(mag);
                dsum = dsum + du[i];
                cnt = cnt + 1;
            end else begin
                tim[j] = tim[i];
                dr[j]  = dr[i];
                du[j]  = du[i];
            end
        end
        if (cnt != 0) begin
            res = sum / longint'(cnt);
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
            if (dsum / cnt > HIGH_DUTY) begin
                if (res > longint'(peak)) peak = res[31:0];
                else peak = 32'((19 * longint'(peak) + res) / 20);
            end
            rpm = res[31:0];
        end
    endtask

    task automatic predict_speed(input logic [1:0] op, input logic a, input logic b,
                                 input logic [31:0] now, input logic [7:0] d,
                                 output speed_out_t o);
        logic [31:0]      rpm;
        logic [31:0]      gap;
        logic [IDX_W-1:0] last;
        rpm = 0;
        case (op)
            OP_EDGE: begin
                if (a ^ b) begin
                    push_event(now, DIR_REV, d);
                    ticks = ticks - 1;
                end else begin
                    push_event(now, DIR_FWD, d);
                    ticks = ticks + 1;
                end
            end
            OP_TIMEOUT: begin
                last = slot - 1'b1;
                gap = now - ev_time[last];
                if (gap >= stall_to) begin
                    push_event(now, DIR_STALL, d);
                    if (d > ntd) ntd = d;
                    kick = 1'b1;
                end else if (d < weak_level(ntd)) begin
                    ntd = (ntd > DUTY_STEP) ? ntd - DUTY_STEP : 8'd0;
                end
            end
            OP_QUERY: begin
                average_rpm(now, rpm);
            end
            default: begin
                ticks = 0;
                for (int k = 0; k < HIST_DEPTH; k++) begin
                    ev_time[k] = 0;
                    ev_dir[k] = DIR_STALL;
                end
            end
        endcase
        o.rpm = rpm;
        o.max_rpm = peak;
        o.pos = ticks;
        o.stall = ntd;
        o.weak_duty = weak_level(ntd);
        o.kick = kick;
    endtask

    // watch all channels at the rising edge
    always @(posedge aclk) begin
        speed_out_t want;
        speed_out_t got;
        if (!aresetn) begin
            tpr = TPR_RST;
            gear = GEAR_RST;
            stall_to = TIMEOUT_RST;
            win = WINDOW_RST;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                ev_time[k] = 0;
                ev_dir[k] = DIR_STALL;
                ev_duty[k] = 0;
            end
            slot = 0;
            ticks = 0;
            peak = 0;
            ntd = NTD_RST;
            kick = 1'b1;
            expected_outputs.delete();
            errors = 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TPR:     tpr = cfg_data[12:0];
                    CFG_GEAR:    gear = cfg_data[10:0];
                    CFG_TIMEOUT: stall_to = cfg_data;
                    CFG_WINDOW:  win = cfg_data;
                    default: ;
                endcase
            end
            // compare a returned result with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.rpm = m_tdata[31:0];
                got.max_rpm = m_tdata[63:32];
                got.pos = m_tdata[95:64];
                got.stall = m_tdata[103:96];
                got.weak_duty = m_tdata[111:104];
                got.kick = m_tdata[112];
                if (expected_outputs.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result rpm=%0d pos=%0d", $signed(got.rpm),
                                 $signed(got.pos));
                end else begin
                    want = expected_outputs.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch expected rpm=%0d max=%0d pos=%0d stall=%0d weak=%0d kick=%0b",
                                     $signed(want.rpm), $signed(want.max_rpm),
                                     $signed(want.pos), want.stall, want.weak_duty,
                                     want.kick);
                            $display("         actual   rpm=%0d max=%0d pos=%0d stall=%0d weak=%0d kick=%0b",
                                     $signed(got.rpm), $signed(got.max_rpm),
                                     $signed(got.pos), got.stall, got.weak_duty, got.kick);
                        end
                    end
                end
            end
            // predict an accepted item
            if (s_tvalid && s_tready) begin
                predict_speed(s_tuser, s_tdata[0], s_tdata[1], s_tdata[33:2],
                              s_tdata[41:34], want);
                expected_outputs.push_back(want);
            end
        end
        pending = expected_outputs.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the encoder speed estimator: directed edge,
// timeout, query and clear items, then random encoder traffic
// under several register settings, with random stalls on both sides.
// ---------------------------------------------------------------------------
module tb;
    import ces_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // enc_a, enc_b, now_us[31:0], duty[7:0]
    logic [1:0]           s_tuser;   // operation[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    // rpm[31:0], max_rpm[31:0], position_ticks[31:0], stall_duty[7:0],
    // weak_duty[7:0], kick_needed
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int errors;
    int pending;
    int op_count [4];
    int results_seen;
    int settings_run;
    int idle_cycles;
    bit send_burst;
    bit recv_burst;
    logic [31:0] now_t;

    encoder_speed_estimator dut (.*);

    speed_checker checker_i (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog on cycles with no handshake at all
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls, burst stretches, one long hold-off
    initial begin
        int gap;
        m_tready = 1'b0;
        results_seen = 0;
        recv_burst = 1'b0;
        @(posedge aresetn);
        forever begin
            if (results_seen % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
            gap = recv_burst ? 0 : $urandom_range(0, 9);
            @(negedge aclk);
            if (results_seen == 120) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_seen++;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic a, input logic b,
                             input logic [31:0] now, input logic [7:0] d);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {6'd0, d, now, b, a};
        s_tuser = op;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        op_count[op]++;
    endtask

    // registers are written only once every result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        s_tvalid = 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(negedge aclk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] tpr, input logic [31:0] gear,
                            input logic [31:0] to, input logic [31:0] win);
        write_reg(CFG_TPR, tpr);
        write_reg(CFG_GEAR, gear);
        write_reg(CFG_TIMEOUT, to);
        write_reg(CFG_WINDOW, win);
        settings_run++;
    endtask

    function automatic logic [31:0] time_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom_range(0, 10);
        if (r < 75) return $urandom_range(11, 3000);
        if (r < 95) return $urandom_range(3000, 120000);
        return $urandom;
    endfunction

    // mostly encoder edges and queries on an advancing clock
    task automatic random_items(input int n);
        int r;
        logic [1:0] op;
        logic [7:0] d;
        for (int k = 0; k < n; k++) begin
            if (k % 30 == 0) send_burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 50) op = OP_EDGE;
            else if (r < 65) op = OP_TIMEOUT;
            else if (r < 96) op = OP_QUERY;
            else op = OP_CLEAR;
            d = ($urandom_range(0, 99) < 40) ? 8'($urandom_range(231, 255))
                                             : 8'($urandom_range(0, 255));
            now_t = now_t + time_step();
            send_item(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), now_t, d);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_EDGE;
        cfg_valid = 1'b0;
        cfg_index = CFG_TPR;
        cfg_data = '0;
        send_burst = 1'b0;
        settings_run = 1;
        foreach (op_count[k]) op_count[k] = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: all encoder levels, duty extremes, short intervals, stall
        // and non-stall checks, time wrap, clear
        send_item(OP_EDGE, 0, 0, 32'd100, 8'd255);
        send_item(OP_EDGE, 0, 1, 32'd1000, 8'd0);
        send_item(OP_EDGE, 1, 0, 32'd2000, 8'd240);
        send_item(OP_EDGE, 1, 1, 32'd2005, 8'd240);
        send_item(OP_QUERY, 0, 0, 32'd2010, 8'd0);
        send_item(OP_TIMEOUT, 0, 0, 32'd2020, 8'd10);
        send_item(OP_TIMEOUT, 1, 1, 32'd200000, 8'd255);
        send_item(OP_QUERY, 0, 0, 32'd200010, 8'd0);
        for (int k = 0; k < 6; k++)
            send_item(OP_EDGE, 0, 0, 32'd201000 + k * 1000, 8'd250);
        send_item(OP_QUERY, 1, 1, 32'd207000, 8'd0);
        send_item(OP_QUERY, 0, 0, 32'd207500, 8'd0);
        send_item(OP_EDGE, 1, 0, 32'hFFFF_FFF0, 8'd255);
        send_item(OP_EDGE, 0, 1, 32'h0000_0005, 8'd255);
        send_item(OP_EDGE, 0, 0, 32'h0000_0100, 8'd255);
        send_item(OP_QUERY, 0, 0, 32'h0000_0200, 8'd255);
        send_item(OP_CLEAR, 1, 1, 32'hFFFF_FFFF, 8'd255);
        send_item(OP_QUERY, 0, 0, 32'h0000_0300, 8'd0);
        send_item(OP_TIMEOUT, 0, 0, 32'hFFFF_FFFF, 8'd0);
        send_item(OP_EDGE, 1, 1, 32'hFFFF_FFFF, 8'd128);

        // random traffic over several register settings
        now_t = $urandom;
        random_items(100);
        set_regs(1, 1, 1, 32'hFFFF_FFFF);
        now_t = 32'hFFF0_0000;
        random_items(90);
        set_regs(4096, 1024, 32'hFFFF_FFFF, 1);
        random_items(90);
        set_regs(0, 0, 5000, 50000);
        write_reg(CFG_IDX_W'(7), $urandom);
        random_items(90);
        set_regs($urandom_range(1, 4096), $urandom_range(1, 16),
                 $urandom_range(200, 20000), $urandom_range(1000, 500000));
        random_items(90);
        set_regs(TPR_RST, GEAR_RST, TIMEOUT_RST, WINDOW_RST);
        random_items(80);

        // drain
        @(negedge aclk);
        s_tvalid = 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (20) @(negedge aclk);

        $display("covered %0d edges, %0d timeout checks, %0d queries, %0d clears",
                 op_count[OP_EDGE], op_count[OP_TIMEOUT], op_count[OP_QUERY],
                 op_count[OP_CLEAR]);
        $display("over %0d register settings, %0d mismatches", settings_run, errors);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ces_pkg.sv
rtl/ces_div.sv
rtl/ces_datapath.sv
rtl/ces_ctrl.sv
rtl/encoder_speed_estimator.sv
tb/speed_checker.sv
tb/tb.sv
